[sv/wsq_pkg.sv]
// wsq_pkg: shared types, constants and the quarter-wave sine table for the
// waveform synthesizer / quantizer. No dependencies; imported by every module except wsq_fifo.

package wsq_pkg;

    // Phase accumulator and sine table geometry
    localparam int unsigned PHASE_BITS       = 32;
    localparam int unsigned SINE_TABLE_DEPTH = 1024;
    localparam int unsigned SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned SINE_K_BITS      = SINE_IDX_BITS + 1;

    // Datapath widths
    localparam int unsigned STEP_W      = 32;
    localparam int unsigned AMP_W       = 28;
    localparam int unsigned WAVE_W      = 18;  // Q2.16, -1.0 .. +1.0
    localparam int unsigned SINE_W      = 17;  // unsigned Q1.16, 0 .. 1.0
    localparam int unsigned PROD_W      = 46;
    localparam int unsigned MAG_W       = PROD_W - 1;
    localparam int unsigned ROUND_SHIFT = 24;
    localparam int unsigned RMAG_W      = MAG_W - ROUND_SHIFT;
    localparam int unsigned SAMPLE_W    = 22;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned SAW_BITS    = 17;
    localparam int unsigned TRI_BITS    = 18;

    // Waveform selection codes
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_TRI    = 2'd3;

    // Output depth codes (anything else passes unclamped)
    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 2'd3;

    // Q2.16 waveform constants
    localparam logic signed [WAVE_W-1:0] Q16_ONE     = 18'sd65536;
    localparam logic signed [WAVE_W-1:0] Q16_NEG_ONE = -18'sd65536;
    localparam logic [TRI_BITS-1:0]      TRI_QUARTER = 18'd65536;
    localparam logic [TRI_BITS-1:0]      TRI_3QUART  = 18'd196608;
    localparam logic [TRI_BITS-1:0]      TRI_TWO     = 18'd131072;

    // Clamp limits
    localparam logic signed [SAMPLE_W-1:0] S8_MAX  = 22'sd127;
    localparam logic signed [SAMPLE_W-1:0] S8_MIN  = -22'sd128;
    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 22'sd32767;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = -22'sd32768;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [1:0]        wave_kind;
        logic [STEP_W-1:0] phase_step;
        logic [AMP_W-1:0]  amplitude;
        logic [1:0]        sample_bits;
    } t_cfg;

    // Classified item passed from the front end to the back end
    typedef struct packed {
        logic                     is_sine;
        logic                     neg;
        logic [SINE_K_BITS-1:0]   k;
        logic signed [WAVE_W-1:0] lin;
    } t_item;

    // Finished result
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_result;

    // Quarter-wave sine table, built at elaboration from a Q30 Taylor series
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef logic [SINE_W-1:0] t_sine_val;
    typedef t_sine_val t_sine_rom [0:SINE_TABLE_DEPTH];

    function automatic t_sine_val quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 8192) >>> 14;
        if (r > 65536) begin
            r = 65536;
        end
        return SINE_W'(r);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

[sv/wsq_fifo.sv]
// wsq_fifo: small synchronous FIFO in flip-flops with a fill count.
// Depends on nothing; used for the classify queue and the result queue.

module wsq_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic                         i_rd,
    output logic [WIDTH-1:0]             o_rdata,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_wr, w_do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];

    assign w_do_wr = i_wr & ~o_full;
    assign w_do_rd = i_rd & ~o_empty;

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_wr) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (w_do_rd) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_wr && w_do_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[sv/wsq_front.sv]
// wsq_front: phase accumulator and waveform classification.
// Depends on wsq_pkg; feeds classified items into the queue before wsq_back.

module wsq_front import wsq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  logic  i_restart,
    input  logic  i_q_full,
    input  t_cfg  i_cfg,
    output logic  o_wr,
    output t_item o_item
);

    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [PHASE_BITS-1:0]    w_phase;
    logic                     w_accept;
    logic [1:0]               w_quad;
    logic [SINE_IDX_BITS-1:0] w_idx;
    logic [SINE_K_BITS-1:0]   w_k;
    logic [SAW_BITS-1:0]      w_saw_frac;
    logic [TRI_BITS-1:0]      w_tri_u;
    logic signed [WAVE_W-1:0] w_tri;
    logic signed [WAVE_W-1:0] w_lin;

    assign w_accept = i_push & ~i_q_full;

    // phase used by this sample; restart clears it first
    assign w_phase = i_restart ? '0 : r_phase;

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            n_phase = w_phase + i_cfg.phase_step[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // sine: quadrant and mirrored table index
    assign w_quad = w_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = w_phase[PHASE_BITS-3 -: SINE_IDX_BITS];
    assign w_k    = w_quad[0] ? SINE_K_BITS'(SINE_TABLE_DEPTH) - {1'b0, w_idx}
                              : {1'b0, w_idx};

    // triangle: rising, falling, rising again (wraps in 18 bits)
    assign w_tri_u = w_phase[PHASE_BITS-1 -: TRI_BITS];
    always_comb begin
        if (w_tri_u < TRI_QUARTER) begin
            w_tri = $signed(w_tri_u);
        end else if (w_tri_u < TRI_3QUART) begin
            w_tri = $signed(TRI_TWO - w_tri_u);
        end else begin
            w_tri = $signed(w_tri_u);
        end
    end

    assign w_saw_frac = w_phase[PHASE_BITS-1 -: SAW_BITS];

    // linear waveforms by kind
    always_comb begin
        unique case (i_cfg.wave_kind)
            WAVE_SAW:    w_lin = $signed({1'b0, w_saw_frac}) - Q16_ONE;
            WAVE_SQUARE: w_lin = w_phase[PHASE_BITS-1] ? Q16_NEG_ONE : Q16_ONE;
            WAVE_TRI:    w_lin = w_tri;
            default:     w_lin = '0;
        endcase
    end

    assign o_wr           = w_accept;
    assign o_item.is_sine = (i_cfg.wave_kind == WAVE_SINE);
    assign o_item.neg     = w_quad[1];
    assign o_item.k       = w_k;
    assign o_item.lin     = w_lin;

endmodule

[sv/wsq_back.sv]
// wsq_back: table read, amplitude multiply, rounding and clamping, result queue.
// Depends on wsq_pkg and wsq_fifo; drains the classify queue from wsq_front.

module wsq_back import wsq_pkg::*; #(
    parameter int unsigned OUT_Q_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_q_empty,
    input  t_item                      i_q_item,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_clipped
);

    localparam int unsigned CW = $clog2(OUT_Q_DEPTH + 1);

    // stage 1: table read
    logic                     r_s1_valid;
    logic [SINE_W-1:0]        r_s1_sine;
    logic                     r_s1_is_sine;
    logic                     r_s1_neg;
    logic signed [WAVE_W-1:0] r_s1_lin;
    // stage 2: product
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prod;

    logic signed [WAVE_W-1:0]   w_wave;
    logic signed [WAVE_W-1:0]   w_sine_s;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       w_neg;
    logic [MAG_W-1:0]           w_mag;
    logic [MAG_W-1:0]           w_rsum;
    logic [RMAG_W-1:0]          w_rmag;
    logic signed [SAMPLE_W-1:0] w_q;
    t_result                    w_res;
    t_result                    w_out;
    logic [CW-1:0]              w_out_count;
    logic                       w_out_full;
    logic [CW:0]                w_pending;

    // take an item only when the result queue has room for everything in flight
    assign w_pending = {1'b0, w_out_count} + (CW+1)'(r_s1_valid) + (CW+1)'(r_s2_valid);
    assign o_q_pop   = ~i_q_empty & (w_pending < (CW+1)'(OUT_Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_q_pop;
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage 1 payload: registered table read
    always_ff @(posedge i_clk) begin
        r_s1_sine    <= SINE_ROM[i_q_item.k];
        r_s1_is_sine <= i_q_item.is_sine;
        r_s1_neg     <= i_q_item.neg;
        r_s1_lin     <= i_q_item.lin;
    end

    // stage 2: waveform value times amplitude
    assign w_sine_s = $signed({1'b0, r_s1_sine});
    assign w_wave   = r_s1_is_sine ? (r_s1_neg ? -w_sine_s : w_sine_s) : r_s1_lin;
    assign w_prod   = w_wave * $signed({1'b0, i_cfg.amplitude});

    always_ff @(posedge i_clk) begin
        r_s2_prod <= w_prod;
    end

    // round half away from zero
    assign w_neg  = r_s2_prod[PROD_W-1];
    assign w_mag  = w_neg ? MAG_W'(-r_s2_prod) : MAG_W'(r_s2_prod);
    assign w_rsum = w_mag + (MAG_W'(1) << (ROUND_SHIFT - 1));
    assign w_rmag = w_rsum[MAG_W-1:ROUND_SHIFT];
    assign w_q    = w_neg ? -$signed({1'b0, w_rmag}) : $signed({1'b0, w_rmag});

    // saturate to the selected depth
    always_comb begin
        w_res.sample  = w_q;
        w_res.clipped = 1'b0;
        case (i_cfg.sample_bits)
            DEPTH_8: begin
                if (w_q > S8_MAX) begin
                    w_res.sample  = S8_MAX;
                    w_res.clipped = 1'b1;
                end else if (w_q < S8_MIN) begin
                    w_res.sample  = S8_MIN;
                    w_res.clipped = 1'b1;
                end
            end
            DEPTH_16: begin
                if (w_q > S16_MAX) begin
                    w_res.sample  = S16_MAX;
                    w_res.clipped = 1'b1;
                end else if (w_q < S16_MIN) begin
                    w_res.sample  = S16_MIN;
                    w_res.clipped = 1'b1;
                end
            end
            default: begin
                w_res.clipped = 1'b0;
            end
        endcase
    end

    // result queue
    wsq_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_s2_valid),
        .i_wdata (w_res),
        .i_rd    (i_pop),
        .o_rdata (w_out),
        .o_full  (w_out_full),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    assign o_sample  = w_out.sample;
    // full never blocks a write here; it only qualifies the clip flag output
    assign o_clipped = w_out.clipped & (w_out_full | ~o_empty);

endmodule

[sv/waveform_synth_quantizer_unit.sv]
// Waveform synthesizer and PCM quantizer, one sample per accepted push. The
// block sustains one sample per clock cycle while the result queue is popped:
// a push is taken whenever the classify queue is not full, and its result
// passes the classify queue write, the registered sine table read, the
// amplitude multiplier register and the result queue write before it can be
// popped; the back end stalls the classify queue while the result queue lacks
// room for everything in flight. Configuration writes are always ready and
// must be issued only while no sample is in flight.
// Depends on wsq_pkg, wsq_fifo, wsq_front and wsq_back.

module waveform_synth_quantizer_unit import wsq_pkg::*; #(
    parameter int unsigned MID_Q_DEPTH = 2,
    parameter int unsigned OUT_Q_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample requests
    input  logic                       push,
    output logic                       full,
    input  logic                       i_restart,
    // results
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_clipped,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg  r_cfg, n_cfg;
    logic  w_front_wr;
    t_item w_front_item;
    t_item w_q_item;
    logic  w_q_empty;
    logic  w_q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WAVE_KIND:   n_cfg.wave_kind   = i_cfg_data[1:0];
                REG_PHASE_STEP:  n_cfg.phase_step  = i_cfg_data[STEP_W-1:0];
                REG_AMPLITUDE:   n_cfg.amplitude   = i_cfg_data[AMP_W-1:0];
                REG_SAMPLE_BITS: n_cfg.sample_bits = i_cfg_data[1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_kind   <= WAVE_SINE;
            r_cfg.phase_step  <= '0;
            r_cfg.amplitude   <= '0;
            r_cfg.sample_bits <= DEPTH_16;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front end: phase and classification
    wsq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_restart (i_restart),
        .i_q_full  (full),
        .i_cfg     (r_cfg),
        .o_wr      (w_front_wr),
        .o_item    (w_front_item)
    );

    // queue between front and back
    wsq_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_Q_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_wr),
        .i_wdata (w_front_item),
        .i_rd    (w_q_pop),
        .o_rdata (w_q_item),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_count ()
    );

    // back end: scale, round, clamp, result queue
    wsq_back #(
        .OUT_Q_DEPTH (OUT_Q_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_sample  (o_sample),
        .o_clipped (o_clipped)
    );

endmodule
